FILE: rtl/wfba_pkg.sv
package wfba_pkg;

  localparam int unsigned NumBinsDefault = 8;
  localparam logic [15:0] DefaultRequestReset = 16'd8;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_GRANTED = 2'd2,
    ST_NOFIT   = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] size_value;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  bin_rank;
    logic [15:0] granted_size;
    logic [15:0] leftover;
  } out_t;

endpackage

FILE: rtl/worst_fit_bin_allocator.sv
// Worst-fit bin allocator.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one item: a load
// of a bin size or an allocate request. Every item yields exactly one result
// on the output channel (out_valid_o / out_ready_i / out_data_o).
// The config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// default request size; it is always ready and should be used while idle.
// The bin sizes live in a single-port-read memory; each entry visited goes
// through a read state and a compare state. A load shifts smaller bins down,
// visiting the entries from the end of the table to the insertion point, and
// skips the last compare when the new bin goes to the top of the table. An
// allocate skips taken bins in the read state, then reads and compares the
// first free bin before giving the result. A full-table load goes straight
// to the result.
// The block accepts one item at a time; in_ready_o is high only between
// items, so the next transfer can come in the same cycle the result appears.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds the block only when a second result is done.
// Reset empties the table and sets the default request to 8; no clearing pass
// is needed because only entries below the fill count are ever read.
module worst_fit_bin_allocator
  import wfba_pkg::*;
#(
  parameter int unsigned NUM_BINS = NumBinsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CW = $clog2(NUM_BINS + 1);
  localparam logic [CW-1:0] FullCount = CW'(NUM_BINS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  opcode_e             op_q, op_d;
  logic [15:0]         val_q, val_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [NUM_BINS-1:0] taken_q, taken_d;
  out_t                res_q, res_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         defreq_q, defreq_d;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [15:0]         wr_data;
  logic [AW-1:0]       rd_addr;
  logic [15:0]         rd_data;
  logic [CW-1:0]       prev_idx;
  logic [AW-1:0]       ptr;

  wfba_bin_store #(
    .DEPTH(NUM_BINS),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign prev_idx = CW'(idx_q - 1'b1);
  assign ptr      = idx_q[AW-1:0];
  // A load walks upward from the end of the table, so it reads the entry
  // just above the slot it may fill.
  assign rd_addr  = (op_q == OP_LOAD) ? prev_idx[AW-1:0] : ptr;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    taken_d     = taken_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    defreq_d    = defreq_q;
    wr_en       = 1'b0;
    wr_addr     = ptr;
    wr_data     = val_q;

    if (cfg_valid_i) begin
      defreq_d = cfg_data_i;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = in_data_i.opcode;
          res_d = '{status: ST_NOFIT, bin_rank: 3'd0, granted_size: 16'd0, leftover: 16'd0};
          if (in_data_i.opcode == OP_LOAD) begin
            val_d = in_data_i.size_value;
            idx_d = cnt_q;
            if (cnt_q == FullCount) begin
              res_d.status = ST_FULL;
              state_d      = S_RESP;
            end else begin
              state_d = S_READ;
            end
          end else begin
            val_d   = (in_data_i.size_value != 16'd0) ? in_data_i.size_value : defreq_q;
            idx_d   = '0;
            state_d = S_READ;
          end
        end
      end

      S_READ: begin
        if (op_q == OP_LOAD) begin
          if (idx_q == '0) begin
            wr_en        = 1'b1;
            wr_data      = val_q;
            taken_d[ptr] = 1'b0;
            cnt_d        = CW'(cnt_q + 1'b1);
            res_d.status = ST_LOADED;
            state_d      = S_RESP;
          end else begin
            state_d = S_EVAL;
          end
        end else begin
          if (idx_q >= cnt_q) begin
            res_d.status = ST_NOFIT;
            state_d      = S_RESP;
          end else if (taken_q[ptr]) begin
            idx_d = CW'(idx_q + 1'b1);
          end else begin
            state_d = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        if (op_q == OP_LOAD) begin
          wr_en = 1'b1;
          if (rd_data < val_q) begin
            wr_data      = rd_data;
            taken_d[ptr] = taken_q[prev_idx[AW-1:0]];
            idx_d        = prev_idx;
            state_d      = S_READ;
          end else begin
            wr_data      = val_q;
            taken_d[ptr] = 1'b0;
            cnt_d        = CW'(cnt_q + 1'b1);
            res_d.status = ST_LOADED;
            state_d      = S_RESP;
          end
        end else begin
          // The first free bin is the largest free one; if it is too small
          // nothing else can fit.
          if (rd_data >= val_q) begin
            taken_d[ptr]       = 1'b1;
            res_d.status       = ST_GRANTED;
            res_d.bin_rank     = 3'(ptr);
            res_d.granted_size = rd_data;
            res_d.leftover     = rd_data - val_q;
          end else begin
            res_d.status = ST_NOFIT;
          end
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_LOAD;
      val_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      taken_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      defreq_q    <= DefaultRequestReset;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      val_q       <= val_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      taken_q     <= taken_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      defreq_q    <= defreq_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCount)
    else $error("fill count exceeds table depth");

  // While a load shifts, the mark just past the loaded bins is briefly in use.
  a_taken_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((taken_q >> cnt_q) == '0))
    else $error("taken mark set beyond the loaded bins");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> (cnt_q == CW'($past(cnt_q) + 1'b1)))
    else $error("fill count changed by other than one");

  a_leftover_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_GRANTED) |->
      (out_data_o.leftover <= out_data_o.granted_size))
    else $error("leftover larger than granted bin");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_valid_q && !out_ready_i) |=> (state_q == S_RESP))
    else $error("result left the pending stage while the output was stalled");

endmodule

FILE: rtl/wfba_bin_store.sv
module wfba_bin_store
  import wfba_pkg::*;
#(
  parameter int unsigned DEPTH = NumBinsDefault,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [15:0]   wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [15:0]   rd_data_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sim/worst_fit_bin_allocator_tb.sv
`timescale 1ns / 100ps

module worst_fit_bin_allocator_tb
  import wfba_pkg::*;
();

  localparam int unsigned NumBins = NumBinsDefault;
  localparam int unsigned RandomPhases = 7;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned DrainCycles = 2 * NumBins + 8;
  localparam int unsigned StallLimit = 5000;

  // Tracks the bin table as the block should see it and keeps the replies that
  // are still owed, oldest first.
  class worst_fit_predictor;
    logic [15:0] sizes[NumBins];
    bit          taken[NumBins];
    int          filled;
    logic [15:0] dflt_request;
    out_t        replies_due[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned settings_seen;
    int unsigned tally[4];

    function new();
      foreach (sizes[k]) begin
        sizes[k] = '0;
        taken[k] = 1'b0;
      end
      filled = 0;
      dflt_request = DefaultRequestReset;
      errors = 0;
      checked = 0;
      settings_seen = 0;
      foreach (tally[k]) tally[k] = 0;
    endfunction

    function void set_default(logic [15:0] value);
      dflt_request = value;
      settings_seen++;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function void predict_item(in_t item);
      out_t        reply;
      int          pos;
      logic [15:0] need;
      reply = '0;
      if (item.opcode == OP_LOAD) begin
        if (filled >= int'(NumBins)) begin
          reply.status = ST_FULL;
        end else begin
          // Equal sizes keep their place; the new bin lands after them.
          pos = 0;
          while (pos < filled && sizes[pos] >= item.size_value) pos++;
          for (int k = filled; k > pos; k--) begin
            sizes[k] = sizes[k - 1];
            taken[k] = taken[k - 1];
          end
          sizes[pos] = item.size_value;
          taken[pos] = 1'b0;
          filled++;
          reply.status = ST_LOADED;
        end
      end else begin
        need = (item.size_value != 16'd0) ? item.size_value : dflt_request;
        reply.status = ST_NOFIT;
        // Only the first free bin is considered, since it is the largest one left.
        for (int k = 0; k < filled; k++) begin
          if (!taken[k]) begin
            if (sizes[k] >= need) begin
              taken[k] = 1'b1;
              reply.status = ST_GRANTED;
              reply.bin_rank = 3'(k);
              reply.granted_size = sizes[k];
              reply.leftover = sizes[k] - need;
            end
            break;
          end
        end
      end
      tally[reply.status]++;
      replies_due.push_back(reply);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
               checked, what, got, want);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (replies_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", int'(got), 0);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", int'(got.status), int'(want.status));
      if (got.bin_rank !== want.bin_rank)
        report_mismatch("bin_rank", 32'(got.bin_rank), 32'(want.bin_rank));
      if (got.granted_size !== want.granted_size)
        report_mismatch("granted_size", 32'(got.granted_size), 32'(want.granted_size));
      if (got.leftover !== want.leftover)
        report_mismatch("leftover", 32'(got.leftover), 32'(want.leftover));
      checked++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  bit steady = 1'b0;
  bit hold_request = 1'b0;

  worst_fit_predictor pred = new();

  wire any_transfer = (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                      (cfg_valid_i && cfg_ready_o);

  worst_fit_bin_allocator #(
    .NUM_BINS(NumBins)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // Results are checked before the new item is predicted, although no reply can
  // leave in the same cycle its item arrives.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) pred.check_result(out_data_o);
      if (in_valid_i && in_ready_o) pred.predict_item(in_data_i);
      if (cfg_valid_i && cfg_ready_o) pred.set_default(cfg_data_i);
    end
  end

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        stall_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (any_transfer) quiet = 0;
      else quiet++;
    end
    $display("worst_fit_bin_allocator verification failed");
    $finish;
  end

  task automatic send_item(opcode_e op, logic [15:0] size);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i.opcode <= op;
    in_data_i.size_value <= size;
    do @(posedge clk_i); while (!in_ready_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The extra edge lets the monitor record the last transfer before the queue
  // is looked at.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pred.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_default(logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    opcode_e     op;
    logic [15:0] size;
    wait (rst_ni);
    @(posedge clk_i);

    // The reset default of 8 applies until the first register write.
    send_item(OP_ALLOC, 16'd5);       // empty table: no free bin at all
    send_item(OP_LOAD, 16'd100);
    send_item(OP_LOAD, 16'hFFFF);
    send_item(OP_LOAD, 16'd100);      // equal size goes after the first 100
    send_item(OP_ALLOC, 16'd0);       // zero request takes the default
    send_item(OP_LOAD, 16'd0);
    send_item(OP_ALLOC, 16'd101);     // largest free bin is one byte short
    send_item(OP_ALLOC, 16'd100);     // exact fit
    send_item(OP_LOAD, 16'd200);      // shifts a taken bin down with its mark
    drain();
    write_default(16'd0);
    send_item(OP_ALLOC, 16'd0);       // zero default: any free bin fits
    send_item(OP_ALLOC, 16'd0);
    drain();
    write_default(16'hFFFF);
    send_item(OP_ALLOC, 16'd0);
    send_item(OP_ALLOC, 16'hFFFF);
    drain();
    write_default(16'd1);
    send_item(OP_ALLOC, 16'd0);
    send_item(OP_LOAD, 16'hFFFF);
    send_item(OP_LOAD, 16'd1);
    send_item(OP_LOAD, 16'd50);       // table now full
    send_item(OP_LOAD, 16'd9);        // refused, table unchanged
    send_item(OP_ALLOC, 16'd0);
    send_item(OP_ALLOC, 16'd0);
    drain();

    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: size = 16'hFFFF;
        1: size = 16'd1;
        2: size = 16'd0;
        default: size = 16'($urandom_range(1, 65535));
      endcase
      write_default(size);
      // One phase runs back to back after a long receiver hold, so the block
      // fills and has to refuse the sender for a while.
      steady = (phase == 3);
      if (phase == 3) hold_request = 1'b1;
      for (n = 0; n < ItemsPerPhase; n++) begin
        op = ($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_LOAD;
        case ($urandom_range(0, 7))
          0: size = 16'h0000;
          1: size = 16'hFFFF;
          2: size = 16'($urandom_range(1, 16));
          default: size = 16'($urandom());
        endcase
        send_item(op, size);
      end
      steady = 1'b0;
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d results under %0d register writes.",
             pred.checked, pred.settings_seen);
    $display("Replies seen: %0d loaded, %0d table full, %0d granted, %0d no fit.",
             pred.tally[ST_LOADED], pred.tally[ST_FULL],
             pred.tally[ST_GRANTED], pred.tally[ST_NOFIT]);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("worst_fit_bin_allocator verification clean");
    end else begin
      $display("worst_fit_bin_allocator verification failed");
    end
    $finish;
  end

endmodule
